// ===== hdl/sws_pkg.sv =====
// Shared types and constants of the stop-and-wait sender.
// No dependencies; the modules of the block refer to it by scoped names.
package sws_pkg;

  localparam int LEN_W   = 10;
  localparam int NAME_W  = 8;
  localparam int RETRY_W = 4;
  localparam int CFG_W   = 10;

  localparam logic [LEN_W-1:0]   CRED_BYTES_RESET  = 10'd1;
  localparam logic [NAME_W-1:0]  NAME_LEN_RESET    = 8'd4;
  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RESET = 4'd5;

  localparam logic [NAME_W-1:0] NAME_MIN       = 8'd4;
  localparam logic [NAME_W-1:0] NAME_MAX       = 8'd100;
  localparam logic [NAME_W-1:0] FIN_NAME_LIMIT = 8'd12;
  localparam logic [LEN_W-1:0]  ACK_LEN        = 10'd2;

  typedef enum logic [2:0] {
    PH_IDLE, PH_HELLO, PH_WRQ, PH_READ, PH_DATA, PH_FIN, PH_DONE, PH_FAIL
  } phase_t;

  typedef enum logic [2:0] {
    REQ_START   = 3'd0,
    REQ_CHUNK   = 3'd1,
    REQ_RX      = 3'd2,
    REQ_TIMEOUT = 3'd3,
    REQ_INTR    = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    EV_NONE, EV_START, EV_CHUNK, EV_RX, EV_TIMEOUT, EV_INTR
  } ev_kind_t;

  typedef enum logic [2:0] {
    ACT_WAIT      = 3'd0,
    ACT_SEND      = 3'd1,
    ACT_REQ_CHUNK = 3'd2,
    ACT_FINISHED  = 3'd3,
    ACT_FAILED    = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    K_HELLO = 2'd0,
    K_WRQ   = 2'd1,
    K_DATA  = 2'd2,
    K_FIN   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_CRED     = 3'd1,
    ERR_NAME     = 3'd2,
    ERR_RETRY    = 3'd3,
    ERR_REJECT   = 3'd4,
    ERR_READ     = 3'd5,
    ERR_FIN_NAME = 3'd6
  } err_t;

  typedef enum logic [1:0] {
    CFG_CRED_BYTES  = 2'd0,
    CFG_NAME_LEN    = 2'd1,
    CFG_RETRY_LIMIT = 2'd2
  } cfg_idx_t;

  // One input beat after classification by the front end.
  typedef struct packed {
    ev_kind_t         kind;
    logic [LEN_W-1:0] clen;       // chunk length, saturated
    logic             clen_zero;
    logic             eof;
    logic             rerr;
    logic             foreign;    // not from the server
    logic             rx_bad;     // too short or not an ACK
    logic             seq_is0;
    logic             seq_is1;
    logic             rx_payload; // ACK longer than its header
  } ev_t;

  // Head of the event queue as seen by the back end.
  typedef struct packed {
    logic valid;
    ev_t  item;
  } qhead_t;

  typedef struct packed {
    action_t            action;
    kind_t              kind;
    logic               seq;
    logic [LEN_W-1:0]   len;
    logic [RETRY_W-1:0] attempt;
    err_t               err;
  } result_t;

endpackage

// ===== hdl/sws_in_if.sv =====
// Event channel of the stop-and-wait sender: valid, ready and one event.
// Uses no package.
interface sws_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [9:0] chunk_len;
  logic       at_eof;
  logic       read_error;
  logic       rx_from_server;
  logic       rx_is_ack;
  logic [7:0] rx_seq;
  logic [9:0] rx_len;

  modport source (
    output valid, req_type, chunk_len, at_eof, read_error, rx_from_server, rx_is_ack,
           rx_seq, rx_len,
    input  ready
  );
  modport sink (
    input  valid, req_type, chunk_len, at_eof, read_error, rx_from_server, rx_is_ack,
           rx_seq, rx_len,
    output ready
  );
endinterface

// ===== hdl/sws_out_if.sv =====
// Result channel of the stop-and-wait sender: valid, ready and one action.
// Uses no package.
interface sws_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [1:0] pdu_kind;
  logic       pdu_seq;
  logic [9:0] payload_len;
  logic [3:0] attempt;
  logic [2:0] error_code;

  modport source (
    output valid, action, pdu_kind, pdu_seq, payload_len, attempt, error_code,
    input  ready
  );
  modport sink (
    input  valid, action, pdu_kind, pdu_seq, payload_len, attempt, error_code,
    output ready
  );
endinterface

// ===== hdl/stop_and_wait_sender_unit.sv =====
// Top level of the stop-and-wait upload sender controller.
// Depends on sws_pkg, sws_in_if, sws_out_if, sws_front and sws_back.
//
//   channel | role   | beat carries
//   --------+--------+---------------------------------------------------------
//   req     | sink   | one event: start, chunk read, received PDU, timeout, intr
//   rsp     | source | one action: wait, send PDU, request chunk, done, failed
//   cfg_*   | write  | credential length (0), name_len (1), retry_limit (2)
//
// Every event beat yields exactly one result beat. The event passes through
// the queue and then the result register before its result is presented.
// One event per cycle is sustained while rsp takes every result; the phase
// machine in the back end decides each event combinationally.
// A two-entry queue between front and back end keeps taking req beats while
// a stalled result sits in the result register, until both entries are full;
// then req.ready drops until rsp drains.
// Synchronous reset empties the queue and the result register, returns the
// phase machine to idle and loads the register defaults.
module stop_and_wait_sender_unit #(
  parameter int MAX_CHUNK = 512
) (
  input  logic       clk,
  input  logic       rst,
  sws_in_if.sink     req,
  sws_out_if.source  rsp,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data
);

  // Classified event at the head of the queue, and the back end's take strobe.
  sws_pkg::qhead_t head;
  logic            pop;

  // The front end decodes the request type and precomputes the checks that
  // depend only on the beat itself (length saturation, source, ACK form, seq).
  sws_front #(
    .MAX_CHUNK (MAX_CHUNK)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .pop  (pop),
    .head (head)
  );

  // The back end owns the phase machine, the retry counter and the result
  // register; it takes a queued event whenever the result register is free
  // or being emptied in the same cycle.
  sws_back #(
    .MAX_CHUNK (MAX_CHUNK)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// ===== hdl/sws_front.sv =====
// Front end: takes event beats, classifies them and queues them (two entries).
// Depends on sws_pkg and sws_in_if.
module sws_front #(
  parameter int MAX_CHUNK = 512
) (
  input  logic            clk,
  input  logic            rst,
  sws_in_if.sink          req,
  input  logic            pop,
  output sws_pkg::qhead_t head
);

  localparam logic [sws_pkg::LEN_W-1:0] MaxChunkW = sws_pkg::LEN_W'(MAX_CHUNK);

  sws_pkg::ev_t classified;
  sws_pkg::ev_t fifo [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         push;

  always_comb begin
    classified = '0;
    case (sws_pkg::req_t'(req.req_type))
      sws_pkg::REQ_START:   classified.kind = sws_pkg::EV_START;
      sws_pkg::REQ_CHUNK:   classified.kind = sws_pkg::EV_CHUNK;
      sws_pkg::REQ_RX:      classified.kind = sws_pkg::EV_RX;
      sws_pkg::REQ_TIMEOUT: classified.kind = sws_pkg::EV_TIMEOUT;
      sws_pkg::REQ_INTR:    classified.kind = sws_pkg::EV_INTR;
      default:              classified.kind = sws_pkg::EV_NONE;
    endcase
    classified.clen       = (req.chunk_len > MaxChunkW) ? MaxChunkW : req.chunk_len;
    classified.clen_zero  = (req.chunk_len == '0);
    classified.eof        = req.at_eof;
    classified.rerr       = req.read_error;
    classified.foreign    = !req.rx_from_server;
    classified.rx_bad     = (req.rx_len < sws_pkg::ACK_LEN) || !req.rx_is_ack;
    classified.seq_is0    = (req.rx_seq == 8'd0);
    classified.seq_is1    = (req.rx_seq == 8'd1);
    classified.rx_payload = (req.rx_len > sws_pkg::ACK_LEN);
  end

  assign req.ready  = !count[1];
  assign push       = req.valid && !count[1];
  assign head.valid = (count != 2'd0);
  assign head.item  = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && head.valid) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop && head.valid})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/sws_back.sv =====
// Back end: transfer phase machine, configuration registers and result register.
// Depends on sws_pkg and sws_out_if.
module sws_back #(
  parameter int MAX_CHUNK = 512
) (
  input  logic                       clk,
  input  logic                       rst,
  input  sws_pkg::qhead_t            head,
  output logic                       pop,
  sws_out_if.source                  rsp,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [sws_pkg::CFG_W-1:0]  cfg_data
);

  localparam logic [sws_pkg::LEN_W-1:0] MaxChunkW = sws_pkg::LEN_W'(MAX_CHUNK);

  typedef enum logic [2:0] {OP_NONE, OP_NEW, OP_RESEND, OP_FAIL, OP_REQ, OP_DONE} op_t;

  // Configuration.
  logic [sws_pkg::LEN_W-1:0]   cred_bytes;
  logic [sws_pkg::NAME_W-1:0]  name_len;
  logic [sws_pkg::RETRY_W-1:0] retry_limit;

  // Transfer state.
  sws_pkg::phase_t             phase, phase_next;
  logic                        data_seq, data_seq_next;
  logic                        last_data_seq, last_data_seq_next;
  logic                        data_sent, data_sent_next;
  logic [sws_pkg::RETRY_W-1:0] fail_count, fail_count_next;
  sws_pkg::kind_t              pending_kind, pending_kind_next;
  logic                        pending_seq, pending_seq_next;
  logic [sws_pkg::LEN_W-1:0]   pending_len, pending_len_next;

  // Decision for the event at the queue head.
  op_t                         op;
  sws_pkg::phase_t             new_phase;
  sws_pkg::kind_t              new_kind;
  logic                        new_seq;
  logic [sws_pkg::LEN_W-1:0]   new_len;
  sws_pkg::err_t               fail_err;
  logic [sws_pkg::RETRY_W-1:0] fc_val;
  logic                        wrq_done;
  logic                        data_done;

  logic [sws_pkg::RETRY_W-1:0] fc_inc;
  logic [sws_pkg::RETRY_W-1:0] lim;
  logic [sws_pkg::LEN_W-1:0]   name_pdu_len;
  logic                        waiting;
  logic                        seq_match;
  logic                        fin_ok;
  sws_pkg::result_t            result;
  sws_pkg::result_t            out_reg;
  logic                        out_valid;

  assign fc_inc       = fail_count + 4'd1;
  assign lim          = (retry_limit == '0) ? 4'd1 : retry_limit;
  assign name_pdu_len = {2'b00, name_len} + 10'd1;
  assign fin_ok       = (name_len < sws_pkg::FIN_NAME_LIMIT);
  assign seq_match    = pending_seq ? head.item.seq_is1 : head.item.seq_is0;
  assign waiting      = (phase == sws_pkg::PH_HELLO) || (phase == sws_pkg::PH_WRQ) ||
                        (phase == sws_pkg::PH_DATA)  || (phase == sws_pkg::PH_FIN);

  assign pop = head.valid && (!out_valid || rsp.ready);

  // Decide what the head event does.
  always_comb begin
    op        = OP_NONE;
    new_phase = phase;
    new_kind  = sws_pkg::K_HELLO;
    new_seq   = 1'b0;
    new_len   = '0;
    fail_err  = sws_pkg::ERR_NONE;
    fc_val    = fail_count;
    wrq_done  = 1'b0;
    data_done = 1'b0;
    case (head.item.kind)
      sws_pkg::EV_START: begin
        if (phase == sws_pkg::PH_IDLE || phase == sws_pkg::PH_DONE ||
            phase == sws_pkg::PH_FAIL) begin
          fc_val = '0;
          if (cred_bytes == '0 || cred_bytes > MaxChunkW) begin
            op       = OP_FAIL;
            fail_err = sws_pkg::ERR_CRED;
          end else begin
            op        = OP_NEW;
            new_phase = sws_pkg::PH_HELLO;
            new_kind  = sws_pkg::K_HELLO;
            new_len   = cred_bytes;
          end
        end
      end
      sws_pkg::EV_CHUNK: begin
        if (phase == sws_pkg::PH_READ) begin
          if (!head.item.clen_zero) begin
            op        = OP_NEW;
            new_phase = sws_pkg::PH_DATA;
            new_kind  = sws_pkg::K_DATA;
            new_seq   = data_seq;
            new_len   = head.item.clen;
          end else if (head.item.eof) begin
            if (!data_sent) begin
              op        = OP_NEW;
              new_phase = sws_pkg::PH_DATA;
              new_kind  = sws_pkg::K_DATA;
              new_seq   = data_seq;
            end else if (fin_ok) begin
              op        = OP_NEW;
              new_phase = sws_pkg::PH_FIN;
              new_kind  = sws_pkg::K_FIN;
              new_seq   = !last_data_seq;
              new_len   = name_pdu_len;
            end else begin
              op       = OP_FAIL;
              fail_err = sws_pkg::ERR_FIN_NAME;
            end
          end else if (head.item.rerr) begin
            op       = OP_FAIL;
            fail_err = sws_pkg::ERR_READ;
          end else begin
            op = OP_REQ;
          end
        end
      end
      sws_pkg::EV_RX: begin
        if (waiting) begin
          if (head.item.foreign) begin
            op = OP_RESEND;
          end else if (head.item.rx_bad) begin
            fc_val = fc_inc;
            if (fc_inc >= lim) begin
              op       = OP_FAIL;
              fail_err = sws_pkg::ERR_RETRY;
            end else begin
              op = OP_RESEND;
            end
          end else if (!seq_match) begin
            op = OP_RESEND;
          end else if (head.item.rx_payload) begin
            op       = OP_FAIL;
            fail_err = sws_pkg::ERR_REJECT;
          end else begin
            // The ACK for the pending PDU.
            fc_val = '0;
            case (phase)
              sws_pkg::PH_HELLO: begin
                if (name_len < sws_pkg::NAME_MIN || name_len > sws_pkg::NAME_MAX) begin
                  op       = OP_FAIL;
                  fail_err = sws_pkg::ERR_NAME;
                end else begin
                  op        = OP_NEW;
                  new_phase = sws_pkg::PH_WRQ;
                  new_kind  = sws_pkg::K_WRQ;
                  new_seq   = 1'b1;
                  new_len   = name_pdu_len;
                end
              end
              sws_pkg::PH_WRQ: begin
                op        = OP_REQ;
                new_phase = sws_pkg::PH_READ;
                wrq_done  = 1'b1;
              end
              sws_pkg::PH_DATA: begin
                data_done = 1'b1;
                if (pending_len == '0) begin
                  if (fin_ok) begin
                    op        = OP_NEW;
                    new_phase = sws_pkg::PH_FIN;
                    new_kind  = sws_pkg::K_FIN;
                    new_seq   = !pending_seq;
                    new_len   = name_pdu_len;
                  end else begin
                    op       = OP_FAIL;
                    fail_err = sws_pkg::ERR_FIN_NAME;
                  end
                end else begin
                  op        = OP_REQ;
                  new_phase = sws_pkg::PH_READ;
                end
              end
              default: begin
                op        = OP_DONE;
                new_phase = sws_pkg::PH_DONE;
              end
            endcase
          end
        end
      end
      sws_pkg::EV_TIMEOUT: begin
        if (waiting) begin
          fc_val = fc_inc;
          if (fc_inc >= lim) begin
            op       = OP_FAIL;
            fail_err = sws_pkg::ERR_RETRY;
          end else begin
            op = OP_RESEND;
          end
        end
      end
      sws_pkg::EV_INTR: begin
        if (waiting) begin
          op = OP_RESEND;
        end
      end
      default: begin
        op = OP_NONE;
      end
    endcase
  end

  // Next state.
  always_comb begin
    phase_next         = phase;
    data_seq_next      = data_seq;
    last_data_seq_next = last_data_seq;
    data_sent_next     = data_sent;
    fail_count_next    = fail_count;
    pending_kind_next  = pending_kind;
    pending_seq_next   = pending_seq;
    pending_len_next   = pending_len;
    if (pop) begin
      fail_count_next = (op == OP_NEW) ? '0 : fc_val;
      case (op)
        OP_NEW: begin
          phase_next        = new_phase;
          pending_kind_next = new_kind;
          pending_seq_next  = new_seq;
          pending_len_next  = new_len;
        end
        OP_FAIL: begin
          phase_next = sws_pkg::PH_FAIL;
        end
        OP_REQ, OP_DONE: begin
          phase_next = new_phase;
        end
        default: begin
          phase_next = phase;
        end
      endcase
      if (wrq_done) begin
        data_seq_next  = 1'b0;
        data_sent_next = 1'b0;
      end
      if (data_done) begin
        last_data_seq_next = pending_seq;
        data_sent_next     = 1'b1;
        data_seq_next      = !data_seq;
      end
    end
  end

  // Result of the head event.
  always_comb begin
    result = '0;
    case (op)
      OP_NEW: begin
        result.action = sws_pkg::ACT_SEND;
        result.kind   = new_kind;
        result.seq    = new_seq;
        result.len    = new_len;
      end
      OP_RESEND: begin
        result.action  = sws_pkg::ACT_SEND;
        result.kind    = pending_kind;
        result.seq     = pending_seq;
        result.len     = pending_len;
        result.attempt = fc_val;
      end
      OP_FAIL: begin
        result.action  = sws_pkg::ACT_FAILED;
        result.attempt = fc_val;
        result.err     = fail_err;
      end
      OP_REQ:  result.action = sws_pkg::ACT_REQ_CHUNK;
      OP_DONE: result.action = sws_pkg::ACT_FINISHED;
      default: result.action = sws_pkg::ACT_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sws_pkg::PH_IDLE;
      data_seq      <= 1'b0;
      last_data_seq <= 1'b0;
      data_sent     <= 1'b0;
      fail_count    <= '0;
      pending_kind  <= sws_pkg::K_HELLO;
      pending_seq   <= 1'b0;
      pending_len   <= '0;
      out_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      data_seq      <= data_seq_next;
      last_data_seq <= last_data_seq_next;
      data_sent     <= data_sent_next;
      fail_count    <= fail_count_next;
      pending_kind  <= pending_kind_next;
      pending_seq   <= pending_seq_next;
      pending_len   <= pending_len_next;
      if (pop) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_reg <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cred_bytes  <= sws_pkg::CRED_BYTES_RESET;
      name_len    <= sws_pkg::NAME_LEN_RESET;
      retry_limit <= sws_pkg::RETRY_LIMIT_RESET;
    end else if (cfg_we) begin
      case (sws_pkg::cfg_idx_t'(cfg_index))
        sws_pkg::CFG_CRED_BYTES:  cred_bytes  <= cfg_data;
        sws_pkg::CFG_NAME_LEN:    name_len    <= cfg_data[sws_pkg::NAME_W-1:0];
        sws_pkg::CFG_RETRY_LIMIT: retry_limit <= cfg_data[sws_pkg::RETRY_W-1:0];
        default: begin
          cred_bytes <= cred_bytes;
        end
      endcase
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.action      = out_reg.action;
  assign rsp.pdu_kind    = out_reg.kind;
  assign rsp.pdu_seq     = out_reg.seq;
  assign rsp.payload_len = out_reg.len;
  assign rsp.attempt     = out_reg.attempt;
  assign rsp.error_code  = out_reg.err;

endmodule

// ===== hdl/sws_checker.sv =====
// Port-level checks of the stop-and-wait sender, bound to the top level.
// Depends on sws_pkg and stop_and_wait_sender_unit.
module sws_checker (
  input logic       clk,
  input logic       rst,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [2:0] action,
  input logic [1:0] pdu_kind,
  input logic       pdu_seq,
  input logic [9:0] payload_len,
  input logic [3:0] attempt,
  input logic [2:0] error_code
);

  // A stalled result beat stays valid and keeps its action, length, attempt and error.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(action) && $stable(attempt) &&
                                $stable(error_code) && $stable(payload_len))
    else $error("result beat changed while stalled");

  // Reset empties the result register.
  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  // An error code shows up exactly on a failure.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((action == 3'(sws_pkg::ACT_FAILED)) == (error_code != 3'(sws_pkg::ERR_NONE))))
    else $error("error code does not match failure action");

  // Only a send carries PDU fields.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (action != 3'(sws_pkg::ACT_SEND)) |->
      (pdu_kind == 2'd0) && !pdu_seq && (payload_len == 10'd0))
    else $error("PDU fields set on a non-send result");

endmodule

bind stop_and_wait_sender_unit sws_checker u_sws_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .action      (rsp.action),
  .pdu_kind    (rsp.pdu_kind),
  .pdu_seq     (rsp.pdu_seq),
  .payload_len (rsp.payload_len),
  .attempt     (rsp.attempt),
  .error_code  (rsp.error_code)
);

// ===== tb/sv/stop_and_wait_sender_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the stop-and-wait upload sender controller.
// It needs sws_pkg, sws_in_if, sws_out_if and the stop_and_wait_sender_unit RTL.
module stop_and_wait_sender_unit_tb;
  import sws_pkg::*;

  localparam int MAX_CHUNK = 512;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [2:0] REQ_CODE_MAX = 3'd7;  // highest code the req_type field can carry
  localparam int NUM_SETTINGS = 12;

  // One event beat as the testbench builds it.
  typedef struct {
    logic [2:0] req;
    logic [9:0] chunk_len;
    logic       at_eof;
    logic       read_error;
    logic       from_server;
    logic       is_ack;
    logic [7:0] seq;
    logic [9:0] rx_len;
  } sws_event_t;

  // Tracks the sender's phase machine on every accepted event and keeps the
  // actions that the block still owes us, oldest first.
  class upload_tracker;
    logic [9:0] cred_bytes;
    logic [7:0] name_len;
    logic [3:0] retry_limit;
    phase_t     phase;
    logic       data_seq;
    logic       last_data_seq;
    logic       data_sent;
    logic [3:0] fail_count;
    kind_t      pend_kind;
    logic       pend_seq;
    logic [9:0] pend_len;
    result_t    due_actions[$];
    int         bad_actions;

    function new();
      cred_bytes = CRED_BYTES_RESET;
      name_len = NAME_LEN_RESET;
      retry_limit = RETRY_LIMIT_RESET;
      phase = PH_IDLE;
      data_seq = 1'b0;
      last_data_seq = 1'b0;
      data_sent = 1'b0;
      fail_count = '0;
      pend_kind = K_HELLO;
      pend_seq = 1'b0;
      pend_len = '0;
      bad_actions = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [9:0] data);
      case (idx)
        CFG_CRED_BYTES:  cred_bytes = data;
        CFG_NAME_LEN:    name_len = data[7:0];
        CFG_RETRY_LIMIT: retry_limit = data[3:0];
        default: ;
      endcase
    endfunction

    function int due_count();
      return due_actions.size();
    endfunction

    function logic is_awaiting();
      return phase == PH_HELLO || phase == PH_WRQ || phase == PH_DATA || phase == PH_FIN;
    endfunction

    function result_t make_result(action_t act, kind_t kind, logic seq, logic [9:0] len,
                                  logic [3:0] att, err_t err);
      result_t r;
      r.action = act;
      r.kind = kind;
      r.seq = seq;
      r.len = len;
      r.attempt = att;
      r.err = err;
      return r;
    endfunction

    function result_t fail_with(err_t err);
      phase = PH_FAIL;
      return make_result(ACT_FAILED, K_HELLO, 1'b0, '0, fail_count, err);
    endfunction

    function result_t resend();
      return make_result(ACT_SEND, pend_kind, pend_seq, pend_len, fail_count, ERR_NONE);
    endfunction

    // A fresh PDU starts with a clean failure count.
    function result_t send_pdu(phase_t ph, kind_t kind, logic seq, logic [9:0] len);
      phase = ph;
      pend_kind = kind;
      pend_seq = seq;
      pend_len = len;
      fail_count = '0;
      return resend();
    endfunction

    // A retry limit of zero behaves like one.
    function result_t count_failure();
      logic [3:0] lim;
      lim = (retry_limit == 4'd0) ? 4'd1 : retry_limit;
      fail_count = fail_count + 4'd1;
      if (fail_count >= lim) return fail_with(ERR_RETRY);
      return resend();
    endfunction

    // FIN carries the filename, which must stay short.
    function result_t finish_data();
      if (name_len >= FIN_NAME_LIMIT) return fail_with(ERR_FIN_NAME);
      return send_pdu(PH_FIN, K_FIN, ~last_data_seq, {2'b00, name_len} + 10'd1);
    endfunction

    function action_t take_event(sws_event_t ev);
      result_t r;
      logic [9:0] clen;
      r = make_result(ACT_WAIT, K_HELLO, 1'b0, '0, '0, ERR_NONE);
      case (ev.req)
        REQ_START: begin
          if (phase == PH_IDLE || phase == PH_DONE || phase == PH_FAIL) begin
            fail_count = '0;
            if (cred_bytes == 10'd0 || cred_bytes > MAX_CHUNK) r = fail_with(ERR_CRED);
            else r = send_pdu(PH_HELLO, K_HELLO, 1'b0, cred_bytes);
          end
        end
        REQ_CHUNK: begin
          if (phase == PH_READ) begin
            clen = (ev.chunk_len > MAX_CHUNK) ? 10'(MAX_CHUNK) : ev.chunk_len;
            if (clen != 10'd0) begin
              r = send_pdu(PH_DATA, K_DATA, data_seq, clen);
            end else if (ev.at_eof) begin
              // An empty file still gets one empty DATA before FIN.
              if (data_sent) r = finish_data();
              else r = send_pdu(PH_DATA, K_DATA, data_seq, '0);
            end else if (ev.read_error) begin
              r = fail_with(ERR_READ);
            end else begin
              r = make_result(ACT_REQ_CHUNK, K_HELLO, 1'b0, '0, '0, ERR_NONE);
            end
          end
        end
        REQ_RX: begin
          if (is_awaiting()) begin
            if (!ev.from_server) begin
              r = resend();
            end else if (ev.rx_len < ACK_LEN || !ev.is_ack) begin
              r = count_failure();
            end else if (ev.seq != {7'b0, pend_seq}) begin
              r = resend();
            end else if (ev.rx_len > ACK_LEN) begin
              r = fail_with(ERR_REJECT);
            end else begin
              fail_count = '0;
              case (phase)
                PH_HELLO: begin
                  if (name_len < NAME_MIN || name_len > NAME_MAX) r = fail_with(ERR_NAME);
                  else r = send_pdu(PH_WRQ, K_WRQ, 1'b1, {2'b00, name_len} + 10'd1);
                end
                PH_WRQ: begin
                  phase = PH_READ;
                  data_seq = 1'b0;
                  data_sent = 1'b0;
                  r = make_result(ACT_REQ_CHUNK, K_HELLO, 1'b0, '0, '0, ERR_NONE);
                end
                PH_DATA: begin
                  last_data_seq = pend_seq;
                  data_sent = 1'b1;
                  data_seq = ~data_seq;
                  if (pend_len == 10'd0) begin
                    r = finish_data();
                  end else begin
                    phase = PH_READ;
                    r = make_result(ACT_REQ_CHUNK, K_HELLO, 1'b0, '0, '0, ERR_NONE);
                  end
                end
                default: begin
                  phase = PH_DONE;
                  r = make_result(ACT_FINISHED, K_HELLO, 1'b0, '0, '0, ERR_NONE);
                end
              endcase
            end
          end
        end
        REQ_TIMEOUT: if (is_awaiting()) r = count_failure();
        REQ_INTR:    if (is_awaiting()) r = resend();
        default: ;
      endcase
      due_actions.push_back(r);
      return r.action;
    endfunction

    function void report(string field, logic [9:0] want, logic [9:0] got);
      bad_actions++;
      $error("%s: expected %0d, got %0d", field, want, got);
    endfunction

    function void match_action(logic [2:0] act, logic [1:0] kind, logic seq, logic [9:0] len,
                               logic [3:0] att, logic [2:0] err);
      result_t want;
      if (due_actions.size() == 0) begin
        bad_actions++;
        $error("result beat with action %0d but none expected", act);
        return;
      end
      want = due_actions.pop_front();
      if (act !== want.action) report("action", 10'(want.action), 10'(act));
      if (kind !== want.kind) report("pdu_kind", 10'(want.kind), 10'(kind));
      if (seq !== want.seq) report("pdu_seq", 10'(want.seq), 10'(seq));
      if (len !== want.len) report("payload_len", want.len, len);
      if (att !== want.attempt) report("attempt", 10'(want.attempt), 10'(att));
      if (err !== want.err) report("error_code", 10'(want.err), 10'(err));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [9:0] cfg_data;

  sws_in_if  req_ch ();
  sws_out_if rsp_ch ();

  upload_tracker tracker;
  int cycle_count = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;

  // Register settings for the random part, one row per phase of the run. They
  // reach both ends of every register and hit each of the configuration
  // failures (credentials, filename, filename too long for FIN).
  int cred_tab  [NUM_SETTINGS] = '{512, 300, 0, 1023, 20, 100, 64, 513, 10, 7, 200, 33};
  int name_tab  [NUM_SETTINGS] = '{11, 7, 5, 255, 3, 101, 12, 6, 4, 0, 100, 9};
  int retry_tab [NUM_SETTINGS] = '{15, 1, 3, 2, 6, 8, 5, 4, 0, 10, 7, 2};
  int items_tab [NUM_SETTINGS] = '{300, 300, 30, 30, 40, 40, 200, 30, 300, 40, 200, 350};

  stop_and_wait_sender_unit #(
    .MAX_CHUNK(MAX_CHUNK)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side. Every beat is checked against the oldest owed action, then
  // ready is redrawn so that stalls land on every phase of the block's work.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready)
        tracker.match_action(rsp_ch.action, rsp_ch.pdu_kind, rsp_ch.pdu_seq,
                             rsp_ch.payload_len, rsp_ch.attempt, rsp_ch.error_code);
      rsp_ch.ready <= ($urandom_range(99, 0) >= snk_idle_pct);
    end
  end

  // Offers one event beat, maybe after a random gap, and waits for the
  // handshake. The tracker sees the beat in the step it is taken.
  task automatic send_event(input sws_event_t ev, output action_t act);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= ev.req;
    req_ch.chunk_len <= ev.chunk_len;
    req_ch.at_eof <= ev.at_eof;
    req_ch.read_error <= ev.read_error;
    req_ch.rx_from_server <= ev.from_server;
    req_ch.rx_is_ack <= ev.is_ack;
    req_ch.rx_seq <= ev.seq;
    req_ch.rx_len <= ev.rx_len;
    do @(posedge clk); while (!req_ch.ready);
    act = tracker.take_event(ev);
  endtask

  // Drops valid and waits until every owed result has been taken. Each event
  // yields exactly one result, so an empty queue means the block is idle.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (tracker.due_count() != 0) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges.
  task automatic load_settings(input logic [9:0] cred, input logic [7:0] name,
                               input logic [3:0] retry);
    cfg_idx_t idx;
    logic [9:0] data;
    for (int i = CFG_CRED_BYTES; i <= CFG_RETRY_LIMIT; i++) begin
      idx = cfg_idx_t'(i);
      case (idx)
        CFG_CRED_BYTES: data = cred;
        CFG_NAME_LEN:   data = {2'b00, name};
        default:        data = {6'b0, retry};
      endcase
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_data <= data;
      tracker.write_reg(idx, data);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic sws_event_t ev_of(logic [2:0] req, logic [9:0] clen, logic eof,
                                       logic rerr, logic from_srv, logic ack,
                                       logic [7:0] seq, logic [9:0] rlen);
    sws_event_t ev;
    ev.req = req;
    ev.chunk_len = clen;
    ev.at_eof = eof;
    ev.read_error = rerr;
    ev.from_server = from_srv;
    ev.is_ack = ack;
    ev.seq = seq;
    ev.rx_len = rlen;
    return ev;
  endfunction

  // Random event shaped by where the transfer stands: mostly the event that
  // moves the upload forward, with retries, stray PDUs and plain noise mixed in.
  function automatic sws_event_t next_event();
    sws_event_t ev;
    int pick;
    ev = ev_of(3'($urandom_range(REQ_CODE_MAX, REQ_START)), 10'($urandom_range(1023, 0)),
               1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
               1'($urandom_range(1, 0)), 8'($urandom_range(255, 0)),
               10'($urandom_range(1023, 0)));
    if ($urandom_range(99, 0) < 12) return ev;
    pick = $urandom_range(99, 0);
    if (tracker.phase == PH_READ) begin
      ev.req = REQ_CHUNK;
      if (pick < 22) begin
        ev.chunk_len = '0;
        ev.at_eof = 1'b1;
      end else if (pick < 30) begin
        ev.chunk_len = '0;
        ev.at_eof = 1'b0;
        ev.read_error = (pick >= 27);
      end else if (pick < 36) begin
        ev.chunk_len = 10'($urandom_range(1023, 1));
      end else begin
        ev.chunk_len = 10'($urandom_range(64, 1));
      end
    end else if (tracker.is_awaiting()) begin
      ev.req = REQ_RX;
      ev.from_server = 1'b1;
      ev.is_ack = 1'b1;
      ev.rx_len = ACK_LEN;
      if (pick < 83 || pick >= 88) ev.seq = {7'b0, tracker.pend_seq};
      if (pick < 68) begin
        // Clean ACK for the PDU in flight.
      end else if (pick < 73) begin
        ev.from_server = 1'b0;
      end else if (pick < 78) begin
        ev.rx_len = 10'($urandom_range(1, 0));
      end else if (pick < 83) begin
        ev.is_ack = 1'b0;
      end else if (pick < 88) begin
        if (ev.seq == {7'b0, tracker.pend_seq}) ev.seq[0] = ~ev.seq[0];
      end else if (pick < 93) begin
        ev.req = REQ_TIMEOUT;
      end else if (pick < 97) begin
        ev.req = REQ_INTR;
      end else begin
        ev.rx_len = 10'($urandom_range(514, 3));
      end
    end else begin
      ev.req = REQ_START;
    end
    return ev;
  endfunction

  initial begin : stimulus
    action_t act;
    int total;
    int counted_here;
    tracker = new();
    total = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_CRED_BYTES;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_START;
    req_ch.chunk_len = '0;
    req_ch.at_eof = 1'b0;
    req_ch.read_error = 1'b0;
    req_ch.rx_from_server = 1'b0;
    req_ch.rx_is_ack = 1'b0;
    req_ch.rx_seq = '0;
    req_ch.rx_len = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part, on the reset values of the registers (credentials of one
    // byte, a four-byte name, five retries). Events outside their phase and an
    // unused request code come first and must only answer wait.
    src_idle_pct = 19;
    snk_idle_pct = 87;
    send_event(ev_of(REQ_CHUNK, 10'd0, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 10'd0), act);
    send_event(ev_of(REQ_CODE_MAX, 10'd0, 1'b0, 1'b0, 1'b1, 1'b1, 8'd0, 10'd2), act);
    send_event(ev_of(REQ_START, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 10'd0), act);
    // A second start while HELLO is out is ignored.
    send_event(ev_of(REQ_START, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 10'd0), act);
    // Foreign source, short PDU, non-ACK, wrong seq, interrupt, timeout.
    send_event(ev_of(REQ_RX, 10'd0, 1'b0, 1'b0, 1'b0, 1'b1, 8'd0, 10'd2), act);
    send_event(ev_of(REQ_RX, 10'd0, 1'b0, 1'b0, 1'b1, 1'b1, 8'd0, 10'd1), act);
    send_event(ev_of(REQ_RX, 10'd0, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 10'd2), act);
    send_event(ev_of(REQ_RX, 10'd0, 1'b0, 1'b0, 1'b1, 1'b1, 8'd255, 10'd2), act);
    send_event(ev_of(REQ_INTR, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 10'd0), act);
    send_event(ev_of(REQ_TIMEOUT, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 10'd0), act);
    send_event(ev_of(REQ_RX, 10'd0, 1'b0, 1'b0, 1'b1, 1'b1, 8'd0, 10'd2), act);
    send_event(ev_of(REQ_RX, 10'd0, 1'b0, 1'b0, 1'b1, 1'b1, 8'd1, 10'd2), act);
    // An oversized chunk saturates; a zero read without eof asks again.
    send_event(ev_of(REQ_CHUNK, 10'd1023, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 10'd0), act);
    send_event(ev_of(REQ_RX, 10'd0, 1'b0, 1'b0, 1'b1, 1'b1, 8'd0, 10'd2), act);
    send_event(ev_of(REQ_CHUNK, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 10'd0), act);
    // A full chunk at eof still goes out as DATA, and an error flag is ignored.
    send_event(ev_of(REQ_CHUNK, 10'd512, 1'b1, 1'b1, 1'b0, 1'b0, 8'd0, 10'd0), act);
    send_event(ev_of(REQ_RX, 10'd0, 1'b0, 1'b0, 1'b1, 1'b1, 8'd1, 10'd2), act);
    send_event(ev_of(REQ_CHUNK, 10'd0, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 10'd0), act);
    // An ACK with a payload makes the server's rejection final.
    send_event(ev_of(REQ_RX, 10'd0, 1'b0, 1'b0, 1'b1, 1'b1, 8'd0, 10'd514), act);
    // Restart after failure with an empty file: one empty DATA, then FIN.
    send_event(ev_of(REQ_START, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 10'd0), act);
    send_event(ev_of(REQ_RX, 10'd0, 1'b0, 1'b0, 1'b1, 1'b1, 8'd0, 10'd2), act);
    send_event(ev_of(REQ_RX, 10'd0, 1'b0, 1'b0, 1'b1, 1'b1, 8'd1, 10'd2), act);
    send_event(ev_of(REQ_CHUNK, 10'd0, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 10'd0), act);
    send_event(ev_of(REQ_RX, 10'd0, 1'b0, 1'b0, 1'b1, 1'b1, 8'd0, 10'd2), act);
    send_event(ev_of(REQ_RX, 10'd0, 1'b0, 1'b0, 1'b1, 1'b1, 8'd1, 10'd2), act);

    // Random part. Idling goes sender-light/receiver-heavy first, then the
    // reverse, then none at all. Every event sent counts toward the total.
    for (int k = 0; k < NUM_SETTINGS; k++) begin
      drain();
      load_settings(10'(cred_tab[k]), 8'(name_tab[k]), 4'(retry_tab[k]));
      counted_here = 0;
      while (counted_here < items_tab[k]) begin
        if (total < 620) begin
          src_idle_pct = 19;
          snk_idle_pct = 87;
        end else if (total < 1240) begin
          src_idle_pct = 87;
          snk_idle_pct = 19;
        end else begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
        send_event(next_event(), act);
        counted_here++;
        total++;
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (tracker.bad_actions == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
